@@ design/ttt_pkg.sv @@
`timescale 1ns / 1ps
package ttt_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int RESULT_CAP    = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ADDR_W = 32;
  localparam int SEQ_W  = 16;
  localparam int TIME_W = 32;
  localparam int HOLD_W = 16;
  localparam int OP_W   = 2;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int ENT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int RCNT_W = $clog2(RESULT_CAP + 1);
  localparam int QP_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(15);

  typedef enum logic [OP_W-1:0] {
    OP_ADV = 2'd0,
    OP_EXP = 2'd1,
    OP_LKP = 2'd2,
    OP_UNK = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] orig;
    logic [SEQ_W-1:0]  seq;
    logic              frag;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] expiry;
  } cmd_t;

endpackage

@@ design/ttt_front.sv @@
`timescale 1ns / 1ps
module ttt_front
  import ttt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [HOLD_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [ADDR_W-1:0] dest_addr_i,
  input  logic [ADDR_W-1:0] orig_addr_i,
  input  logic [SEQ_W-1:0]  seq_num_i,
  input  logic              fragment_i,
  input  logic [TIME_W-1:0] now_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  logic [HOLD_W-1:0] hold_q, hold_d;
  cmd_t              q_mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]   cnt_q, cnt_d;
  logic              full, empty, push, pop;
  cmd_t              cmd_new;

  function automatic logic [QP_W-1:0] ptr_next(input logic [QP_W-1:0] p);
    if (p == QP_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QP_W'(1);
  endfunction

  always_comb begin
    cmd_new.op     = op_e'(operation_i);
    cmd_new.dest   = dest_addr_i;
    cmd_new.orig   = orig_addr_i;
    cmd_new.seq    = seq_num_i;
    cmd_new.frag   = fragment_i;
    cmd_new.now    = now_i;
    cmd_new.expiry = now_i + TIME_W'(hold_q);
  end

  assign full        = (cnt_q == QC_W'(QUEUE_DEPTH));
  assign empty       = (cnt_q == '0);
  assign in_stall_o  = full;
  assign push        = in_valid_i && !full;
  assign pop         = cmd_pop_i && !empty;
  assign cmd_valid_o = !empty;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    hold_d   = cfg_we_i ? cfg_wdata_i : hold_q;
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= HOLD_RESET;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      hold_q   <= hold_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ design/ttt_back.sv @@
`timescale 1ns / 1ps
module ttt_back
  import ttt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              changed_o,
  output logic              status_o,
  output logic              found_o,
  output logic [ADDR_W-1:0] match_dest_o,
  output logic [SEQ_W-1:0]  match_seq_o,
  output logic              last_item_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  localparam int TUP_W = 2 * ADDR_W + SEQ_W;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [TUP_W-1:0]         tup_mem [TABLE_ENTRIES];
  logic [TIME_W-1:0]        exp_mem [TABLE_ENTRIES];
  logic [TUP_W-1:0]         rd_tup_q;
  logic [TIME_W-1:0]        rd_exp_q;

  logic [ENT_W-1:0]  iss_q, iss_d;
  logic              s1_vld_q, s1_vld_d;
  logic [IDX_W-1:0]  s1_idx_q, s1_idx_d;
  logic              chg_q, chg_d;
  logic              hit_q, hit_d, free_q, free_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [RCNT_W-1:0] cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_dest_q, pend_dest_d;
  logic [SEQ_W-1:0]  pend_seq_q, pend_seq_d;

  logic              out_vld_q, out_vld_d;
  logic              out_chg_q, out_sts_q, out_fnd_q, out_last_q;
  logic [ADDR_W-1:0] out_dest_q;
  logic [SEQ_W-1:0]  out_seq_q;

  logic              emit, e_chg, e_sts, e_fnd, e_last;
  logic [ADDR_W-1:0] e_dest;
  logic [SEQ_W-1:0]  e_seq;

  logic              out_free, adv, rd_en, step;
  logic              tup_we, exp_we;
  logic [IDX_W-1:0]  wr_idx;
  logic [ADDR_W-1:0] rd_dest, rd_orig;
  logic [SEQ_W-1:0]  rd_seq;
  logic              v, orig_eq, dest_eq, del, post_v, lkp_hit, need_emit;

  assign rd_dest = rd_tup_q[TUP_W-1 -: ADDR_W];
  assign rd_orig = rd_tup_q[SEQ_W +: ADDR_W];
  assign rd_seq  = rd_tup_q[SEQ_W-1:0];

  assign out_free  = !out_vld_q || !out_stall_i;
  assign v         = valid_q[s1_idx_q];
  assign orig_eq   = (rd_orig == cmd_q.orig);
  assign dest_eq   = (rd_dest == cmd_q.dest);
  assign del       = (cmd_q.op == OP_ADV) && !cmd_q.frag && v && orig_eq && (rd_seq < cmd_q.seq);
  assign post_v    = v && !del;
  assign lkp_hit   = (cmd_q.op == OP_LKP) && v && orig_eq && (cnt_q < RCNT_W'(RESULT_CAP));
  assign need_emit = lkp_hit && pend_q;
  assign adv       = !(s1_vld_q && need_emit && !out_free);
  assign rd_en     = (state_q == ST_SCAN) && adv && (iss_q < ENT_W'(TABLE_ENTRIES));
  assign step      = (state_q == ST_SCAN) && adv && s1_vld_q;
  assign wr_idx    = hit_q ? hit_idx_q : free_idx_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    valid_d     = valid_q;
    iss_d       = iss_q;
    s1_vld_d    = s1_vld_q;
    s1_idx_d    = s1_idx_q;
    chg_d       = chg_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_dest_d = pend_dest_q;
    pend_seq_d  = pend_seq_q;
    cmd_pop_o   = 1'b0;
    tup_we      = 1'b0;
    exp_we      = 1'b0;
    emit        = 1'b0;
    e_chg       = 1'b0;
    e_sts       = 1'b0;
    e_fnd       = 1'b0;
    e_dest      = '0;
    e_seq       = '0;
    e_last      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          iss_d     = '0;
          s1_vld_d  = 1'b0;
          chg_d     = 1'b0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          cnt_d     = '0;
          pend_d    = 1'b0;
          state_d   = (cmd_i.op == OP_UNK) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          s1_vld_d = rd_en;
          if (rd_en) begin
            s1_idx_d = iss_q[IDX_W-1:0];
            iss_d    = iss_q + ENT_W'(1);
          end
        end
        if (step) begin
          case (cmd_q.op)
            OP_ADV: begin
              if (del) begin
                valid_d[s1_idx_q] = 1'b0;
                chg_d             = 1'b1;
              end
              if (post_v && dest_eq && orig_eq && !hit_q) begin
                hit_d     = 1'b1;
                hit_idx_d = s1_idx_q;
              end
              if (!post_v && !free_q) begin
                free_d     = 1'b1;
                free_idx_d = s1_idx_q;
              end
            end
            OP_EXP: begin
              if (v && (rd_exp_q < cmd_q.now)) begin
                valid_d[s1_idx_q] = 1'b0;
                chg_d             = 1'b1;
              end
            end
            OP_LKP: begin
              if (lkp_hit) begin
                if (pend_q) begin
                  emit   = 1'b1;
                  e_fnd  = 1'b1;
                  e_dest = pend_dest_q;
                  e_seq  = pend_seq_q;
                end
                pend_d      = 1'b1;
                pend_dest_d = rd_dest;
                pend_seq_d  = rd_seq;
                cnt_d       = cnt_q + RCNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        if ((iss_q == ENT_W'(TABLE_ENTRIES)) && !s1_vld_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = ST_IDLE;
          case (cmd_q.op)
            OP_ADV: begin
              e_chg = chg_q;
              if (hit_q) begin
                exp_we = 1'b1;
              end else if (!cmd_q.frag) begin
                if (free_q) begin
                  tup_we              = 1'b1;
                  exp_we              = 1'b1;
                  valid_d[free_idx_q] = 1'b1;
                  e_chg               = 1'b1;
                end else begin
                  e_sts = 1'b1;
                end
              end
            end
            OP_EXP: begin
              e_chg = chg_q;
            end
            OP_LKP: begin
              e_fnd  = pend_q;
              e_dest = pend_q ? pend_dest_q : '0;
              e_seq  = pend_q ? pend_seq_q : '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      iss_q     <= '0;
      s1_vld_q  <= 1'b0;
      chg_q     <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      iss_q     <= iss_d;
      s1_vld_q  <= s1_vld_d;
      chg_q     <= chg_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    s1_idx_q    <= s1_idx_d;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    pend_dest_q <= pend_dest_d;
    pend_seq_q  <= pend_seq_d;
    if (emit) begin
      out_chg_q  <= e_chg;
      out_sts_q  <= e_sts;
      out_fnd_q  <= e_fnd;
      out_dest_q <= e_dest;
      out_seq_q  <= e_seq;
      out_last_q <= e_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tup_we) begin
      tup_mem[wr_idx] <= {cmd_q.dest, cmd_q.orig, cmd_q.seq};
    end
    if (rd_en) begin
      rd_tup_q <= tup_mem[iss_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (exp_we) begin
      exp_mem[wr_idx] <= cmd_q.expiry;
    end
    if (rd_en) begin
      rd_exp_q <= exp_mem[iss_q[IDX_W-1:0]];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign changed_o    = out_chg_q;
  assign status_o     = out_sts_q;
  assign found_o      = out_fnd_q;
  assign match_dest_o = out_dest_q;
  assign match_seq_o  = out_seq_q;
  assign last_item_o  = out_last_q;

`ifndef SYNTHESIS
  a_s1_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (state_q == ST_SCAN))
    else $error("evaluation stage busy outside scan");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RCNT_W'(RESULT_CAP))
    else $error("lookup match count beyond cap");

  a_fin_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && out_free |=> out_vld_q && out_last_q)
    else $error("finish step did not present a final word");

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && (cmd_q.op == OP_ADV) && hit_q |-> valid_q[hit_idx_q])
    else $error("refresh target not valid");

  a_no_emit_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("word overwritten while stalled");
`endif

endmodule

@@ design/topology_tuple_table.sv @@
`timescale 1ns / 1ps
// Topology tuple table: holds up to TABLE_ENTRIES routing entries.
// Input channel: in_valid_i / in_stall_o with operation_i, dest_addr_i,
// orig_addr_i, seq_num_i, fragment_i, now_i; a word is taken when valid is
// high and stall is low. A front stage stamps expiry (now + hold time) and
// queues up to two words, so input is taken while the back end is busy.
// Output channel: out_valid_o / out_stall_i with changed_o, status_o,
// found_o, match_dest_o, match_seq_o, last_item_o; last_item_o marks the
// final word of each operation. A lookup gives one word per match, or one if none.
// Configuration: cfg_we_i writes cfg_wdata_i into the hold time register.
// Scan: each operation but an unknown one scans every slot through the
// single read port of the table memory, one slot per cycle while no lookup
// match waits on a stalled output; unknown operations skip the scan. The
// back end finishes one operation before it takes the next from the queue.
// Receiver stall: the output word holds; a lookup scan pauses while a
// further match waits for the output register, then continues.
// Reset: the table empties (all entries invalid), hold time returns to 15,
// queue and output are cleared; no clearing pass is needed.
module topology_tuple_table
  import ttt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [HOLD_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [ADDR_W-1:0] dest_addr_i,
  input  logic [ADDR_W-1:0] orig_addr_i,
  input  logic [SEQ_W-1:0]  seq_num_i,
  input  logic              fragment_i,
  input  logic [TIME_W-1:0] now_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              changed_o,
  output logic              status_o,
  output logic              found_o,
  output logic [ADDR_W-1:0] match_dest_o,
  output logic [SEQ_W-1:0]  match_seq_o,
  output logic              last_item_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  ttt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .dest_addr_i (dest_addr_i),
    .orig_addr_i (orig_addr_i),
    .seq_num_i   (seq_num_i),
    .fragment_i  (fragment_i),
    .now_i       (now_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ttt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .changed_o    (changed_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .match_dest_o (match_dest_o),
    .match_seq_o  (match_seq_o),
    .last_item_o  (last_item_o)
  );

endmodule

@@ tb/tb_topology_tuple_table.sv @@
`timescale 1ns / 1ps
module tb_topology_tuple_table;
  import ttt_pkg::*;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] orig;
    logic [SEQ_W-1:0]  seq;
    logic              frag;
    logic [TIME_W-1:0] now;
  } tuple_req_t;

  typedef struct packed {
    logic              changed;
    logic              status;
    logic              found;
    logic [ADDR_W-1:0] dest;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } tuple_resp_t;

  localparam int N_ORIG = 6;
  localparam int N_DEST = 10;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [HOLD_W-1:0] cfg_wdata_i  = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   operation_i  = '0;
  logic [ADDR_W-1:0] dest_addr_i  = '0;
  logic [ADDR_W-1:0] orig_addr_i  = '0;
  logic [SEQ_W-1:0]  seq_num_i    = '0;
  logic              fragment_i   = 1'b0;
  logic [TIME_W-1:0] now_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic              changed_o;
  logic              status_o;
  logic              found_o;
  logic [ADDR_W-1:0] match_dest_o;
  logic [SEQ_W-1:0]  match_seq_o;
  logic              last_item_o;

  topology_tuple_table uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .dest_addr_i  (dest_addr_i),
    .orig_addr_i  (orig_addr_i),
    .seq_num_i    (seq_num_i),
    .fragment_i   (fragment_i),
    .now_i        (now_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .changed_o    (changed_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .match_dest_o (match_dest_o),
    .match_seq_o  (match_seq_o),
    .last_item_o  (last_item_o)
  );

  always #1 clk_i = ~clk_i;

  bit                tbl_valid  [TABLE_ENTRIES];
  bit [ADDR_W-1:0]   tbl_dest   [TABLE_ENTRIES];
  bit [ADDR_W-1:0]   tbl_orig   [TABLE_ENTRIES];
  bit [SEQ_W-1:0]    tbl_seq    [TABLE_ENTRIES];
  bit [TIME_W-1:0]   tbl_expiry [TABLE_ENTRIES];
  logic [HOLD_W-1:0] tbl_hold = HOLD_RESET;

  tuple_req_t  pending_q[$];
  tuple_resp_t expected_q[$];
  tuple_req_t  cur_req;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int n_req          = 0;
  int n_words        = 0;
  int n_full         = 0;
  int n_purge        = 0;
  int max_hits       = 0;

  logic [ADDR_W-1:0] orig_pool [N_ORIG];
  logic [SEQ_W-1:0]  orig_seq  [N_ORIG];
  logic [ADDR_W-1:0] dest_pool [N_DEST];
  logic [TIME_W-1:0] clock_now = '0;

  function automatic void table_update(input tuple_req_t r);
    tuple_resp_t rsp;
    logic [TIME_W-1:0] expiry;
    int hit;
    int free_slot;
    int total;
    int cnt;
    rsp = '0;
    rsp.last = 1'b1;
    expiry = r.now + TIME_W'(tbl_hold);
    hit = -1;
    free_slot = -1;
    total = 0;
    cnt = 0;
    n_req++;
    case (r.op)
      OP_ADV: begin
        if (!r.frag) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_orig[i] == r.orig && tbl_seq[i] < r.seq) begin
              tbl_valid[i] = 1'b0;
              rsp.changed = 1'b1;
            end
          end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_valid[i]) begin
            if (hit < 0 && tbl_dest[i] == r.dest && tbl_orig[i] == r.orig) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) begin
          tbl_expiry[hit] = expiry;
        end else if (!r.frag) begin
          if (free_slot >= 0) begin
            tbl_valid[free_slot]  = 1'b1;
            tbl_dest[free_slot]   = r.dest;
            tbl_orig[free_slot]   = r.orig;
            tbl_seq[free_slot]    = r.seq;
            tbl_expiry[free_slot] = expiry;
            rsp.changed = 1'b1;
          end else begin
            rsp.status = 1'b1;
            n_full++;
          end
        end
        expected_q.push_back(rsp);
      end
      OP_EXP: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_expiry[i] < r.now) begin
            tbl_valid[i] = 1'b0;
            rsp.changed = 1'b1;
          end
        end
        if (rsp.changed) n_purge++;
        expected_q.push_back(rsp);
      end
      OP_LKP: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_orig[i] == r.orig) total++;
        end
        if (total > RESULT_CAP) total = RESULT_CAP;
        if (total > max_hits) max_hits = total;
        if (total == 0) begin
          expected_q.push_back(rsp);
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_orig[i] == r.orig && cnt < total) begin
              rsp.found = 1'b1;
              rsp.dest  = tbl_dest[i];
              rsp.seq   = tbl_seq[i];
              rsp.last  = (cnt == total - 1);
              expected_q.push_back(rsp);
              cnt++;
            end
          end
        end
      end
      default: begin
        expected_q.push_back(rsp);
      end
    endcase
  endfunction

  function automatic void cmp_field(input string what, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  function automatic void check_word();
    tuple_resp_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual changed=%b status=%b found=%b",
               $time, changed_o, status_o, found_o);
      errors++;
    end else begin
      want = expected_q.pop_front();
      n_words++;
      cmp_field("changed", 32'(want.changed), 32'(changed_o));
      cmp_field("status", 32'(want.status), 32'(status_o));
      cmp_field("found", 32'(want.found), 32'(found_o));
      cmp_field("match_dest", want.dest, match_dest_o);
      cmp_field("match_seq", 32'(want.seq), 32'(match_seq_o));
      cmp_field("last_item", 32'(want.last), 32'(last_item_o));
    end
  endfunction

  // sender: hold a stalled word, advance on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) table_update(cur_req);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          cur_req = pending_q.pop_front();
          operation_i <= cur_req.op;
          dest_addr_i <= cur_req.dest;
          orig_addr_i <= cur_req.orig;
          seq_num_i   <= cur_req.seq;
          fragment_i  <= cur_req.frag;
          now_i       <= cur_req.now;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_word();
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_req(input op_e op, input logic [ADDR_W-1:0] dest,
                          input logic [ADDR_W-1:0] orig, input logic [SEQ_W-1:0] seq,
                          input logic frag, input logic [TIME_W-1:0] now);
    tuple_req_t r;
    r.op   = op;
    r.dest = dest;
    r.orig = orig;
    r.seq  = seq;
    r.frag = frag;
    r.now  = now;
    pending_q.push_back(r);
  endtask

  // empty the table, overfill it from one originator, then read it back
  task automatic queue_flood(inout int n);
    logic [ADDR_W-1:0] org;
    logic [ADDR_W-1:0] base;
    logic [SEQ_W-1:0]  sq;
    org  = $urandom;
    base = $urandom;
    sq   = SEQ_W'($urandom);
    push_req(OP_EXP, '0, '0, '0, 1'b0, '1);
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      push_req(OP_ADV, base + ADDR_W'(k), org, sq, 1'b0, clock_now);
    end
    push_req(OP_LKP, '0, org, '0, 1'b0, clock_now);
    n += TABLE_ENTRIES + 3;
  endtask

  task automatic queue_traffic(input int target, input bit flood_first);
    int n;
    int pick;
    int o;
    tuple_req_t r;
    n = 0;
    if (flood_first) queue_flood(n);
    while (n < target) begin
      pick = $urandom_range(99);
      o = $urandom_range(N_ORIG - 1);
      clock_now += $urandom_range(0, 4);
      if ($urandom_range(99) < 3) clock_now += $urandom_range(0, 100000);
      r = '0;
      r.now = clock_now;
      if (pick < 1) begin
        queue_flood(n);
      end else begin
        if (pick < 11) begin
          r.op   = op_e'($urandom_range(3));
          r.dest = $urandom;
          r.orig = $urandom;
          r.seq  = SEQ_W'($urandom);
          r.frag = 1'($urandom_range(1));
          r.now  = $urandom;
        end else if (pick < 60) begin
          r.op   = OP_ADV;
          r.orig = orig_pool[o];
          r.dest = dest_pool[$urandom_range(N_DEST - 1)];
          r.frag = ($urandom_range(99) < 20);
          case ($urandom_range(9))
            0, 1: begin
              orig_seq[o] += 1'b1;
              r.seq = orig_seq[o];
            end
            2: r.seq = orig_seq[o] - SEQ_W'($urandom_range(1, 3));
            3: r.seq = SEQ_W'($urandom);
            default: r.seq = orig_seq[o];
          endcase
        end else if (pick < 75) begin
          r.op = OP_EXP;
        end else if (pick < 95) begin
          r.op   = OP_LKP;
          r.orig = ($urandom_range(99) < 85) ? orig_pool[o] : ADDR_W'($urandom);
        end else begin
          r.op   = OP_UNK;
          r.dest = $urandom;
          r.orig = $urandom;
        end
        pending_q.push_back(r);
        n++;
      end
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) &&
           guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TABLE_ENTRIES + 8) @(posedge clk_i);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tbl_hold = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] a;
    a = 32'h0a00_0001;
    for (int i = 0; i < N_ORIG; i++) begin
      orig_pool[i] = $urandom;
      orig_seq[i]  = SEQ_W'($urandom_range(0, 40));
    end
    for (int i = 0; i < N_DEST; i++) dest_pool[i] = $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct   = 15;
    recv_stall_pct = 71;
    push_req(OP_LKP, '0, a, '0, 1'b0, 10);
    push_req(OP_EXP, '0, '0, '0, 1'b0, 10);
    push_req(OP_UNK, '1, '1, '1, 1'b1, '1);
    push_req(OP_ADV, 32'h11, a, SEQ_W'(5), 1'b1, 20);
    push_req(OP_ADV, 32'h11, a, SEQ_W'(5), 1'b0, 100);
    push_req(OP_ADV, 32'h11, a, SEQ_W'(5), 1'b0, 110);
    push_req(OP_ADV, 32'h11, a, SEQ_W'(9), 1'b1, 120);
    push_req(OP_ADV, 32'h22, a, SEQ_W'(5), 1'b0, 120);
    push_req(OP_LKP, '0, a, '0, 1'b0, 120);
    push_req(OP_ADV, 32'h33, a, SEQ_W'(7), 1'b0, 130);
    push_req(OP_ADV, 32'h44, a, SEQ_W'(3), 1'b0, 130);
    push_req(OP_LKP, '0, a, '0, 1'b0, 130);
    push_req(OP_ADV, '1, '1, '1, 1'b0, '1);
    push_req(OP_EXP, '0, '0, '0, 1'b0, 100);
    push_req(OP_ADV, '0, '0, '0, 1'b0, '0);
    push_req(OP_LKP, '0, '0, '0, 1'b0, '0);
    push_req(OP_ADV, '0, '0, '0, 1'b1, 200);
    push_req(OP_EXP, '0, '0, '0, 1'b0, 146);
    push_req(OP_EXP, '0, '0, '0, 1'b0, '1);
    push_req(OP_LKP, '0, a, '0, 1'b0, 300);
    clock_now = 300;
    queue_traffic(115, 1'b1);
    drain();

    write_hold('0);
    send_gap_pct   = 71;
    recv_stall_pct = 15;
    queue_traffic(140, 1'b0);
    drain();

    write_hold('1);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    queue_traffic(70, 1'b1);
    drain();

    write_hold(HOLD_W'($urandom_range(1, 65534)));
    queue_traffic(70, 1'b0);
    drain();

    if (expected_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_q.size());
      errors += expected_q.size();
    end
    $display("Covered %0d requests and %0d result words under four hold times.",
             n_req, n_words);
    $display("Table-full drops %0d, purging sweeps %0d, longest lookup %0d words.",
             n_full, n_purge, max_hits);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/ttt_pkg.sv
design/ttt_front.sv
design/ttt_back.sv
design/topology_tuple_table.sv
tb/tb_topology_tuple_table.sv
